// ===== hw/rtl/two_level_page_walker_unit_macros.svh =====
// assertion helpers, sampled on clk and disabled during rst
`ifndef TWO_LEVEL_PAGE_WALKER_UNIT_MACROS_SVH
`define TWO_LEVEL_PAGE_WALKER_UNIT_MACROS_SVH

// same-cycle implication
`define TLPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tlpw_pkg.sv =====
package tlpw_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SMALL_OFS_W = 12;
  localparam int unsigned LARGE_OFS_W = 22;

  localparam logic [2:0] RIGHTS_FULL = 3'd7;
  localparam logic [2:0] RIGHTS_NO_WRITE = 3'd5;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic MODE_REQUEST = 1'b0;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NOT_PRESENT = 2'd1;
  localparam logic [1:0] STATUS_PERM_FAULT = 2'd2;

  localparam logic [1:0] REG_PAGING_ON = 2'd0;
  localparam logic [1:0] REG_WRITE_PROTECT = 2'd1;
  localparam logic [1:0] REG_DIR_BASE = 2'd2;

  localparam int unsigned ENTRY_VALID_BIT = 0;
  localparam int unsigned ENTRY_WRITE_BIT = 1;
  localparam int unsigned ENTRY_LARGE_BIT = 7;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_DIR  = 2'd1,
    PHASE_TAB  = 2'd2
  } phase_t;

  typedef struct packed {
    logic              paging_on;
    logic              write_protect_on;
    logic [ADDR_W-1:0] dir_base;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [ADDR_W-1:0] pend_addr;
    logic [2:0]        pend_rights;
    logic [ADDR_W-1:0] rec_fault;
  } walk_state_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] physical_address;
    logic              large_page;
    logic [2:0]        granted_rights;
    logic [1:0]        status;
    logic [ADDR_W-1:0] last_fault;
  } result_t;

endpackage

// ===== hw/rtl/tlpw_step.sv =====
module tlpw_step
  import tlpw_pkg::*;
(
  input  logic              mode,
  input  logic [ADDR_W-1:0] fault_address,
  input  logic [2:0]        access_wanted,
  input  logic [ADDR_W-1:0] entry_word,
  input  cfg_t              cfg,
  input  walk_state_t       st,
  output walk_state_t       st_next,
  output logic              emit,
  output result_t           res
);

  logic [2:0]        entry_rights;
  logic              perm_fault;
  logic [ADDR_W-1:0] pa_large;
  logic [ADDR_W-1:0] pa_small;
  logic [ADDR_W-1:0] dir_read;
  logic [ADDR_W-1:0] tab_read;

  assign entry_rights = entry_word[ENTRY_WRITE_BIT] ? RIGHTS_FULL : RIGHTS_NO_WRITE;
  assign perm_fault = ((entry_rights & st.pend_rights) != st.pend_rights)
                      && cfg.write_protect_on;

  // offsets and bases occupy disjoint bits, so the sums are concatenations
  assign pa_large = {entry_word[ADDR_W-1:LARGE_OFS_W], st.pend_addr[LARGE_OFS_W-1:0]};
  assign pa_small = {entry_word[ADDR_W-1:SMALL_OFS_W], st.pend_addr[SMALL_OFS_W-1:0]};
  assign dir_read = {cfg.dir_base[ADDR_W-1:SMALL_OFS_W],
                     fault_address[ADDR_W-1:LARGE_OFS_W], 2'b00};
  assign tab_read = {entry_word[ADDR_W-1:SMALL_OFS_W],
                     st.pend_addr[LARGE_OFS_W-1:SMALL_OFS_W], 2'b00};

  always_comb begin
    st_next = st;
    emit = 1'b0;
    res = '0;
    if (mode == MODE_REQUEST) begin
      st_next.pend_addr = fault_address;
      st_next.pend_rights = access_wanted;
      emit = 1'b1;
      if (!cfg.paging_on) begin
        st_next.phase = PHASE_IDLE;
        res.result_kind = KIND_DONE;
        res.physical_address = fault_address;
        res.granted_rights = RIGHTS_FULL;
      end else begin
        st_next.phase = PHASE_DIR;
        res.result_kind = KIND_READ;
        res.read_address = dir_read;
      end
    end else begin
      case (st.phase)
        PHASE_DIR, PHASE_TAB: begin
          emit = 1'b1;
          if (!entry_word[ENTRY_VALID_BIT]) begin
            st_next.phase = PHASE_IDLE;
            st_next.rec_fault = st.pend_addr;
            res.result_kind = KIND_DONE;
            res.physical_address = '1;
            res.granted_rights = RIGHTS_FULL;
            res.status = STATUS_NOT_PRESENT;
          end else if (st.phase == PHASE_DIR && !entry_word[ENTRY_LARGE_BIT]) begin
            st_next.phase = PHASE_TAB;
            res.result_kind = KIND_READ;
            res.read_address = tab_read;
          end else begin
            st_next.phase = PHASE_IDLE;
            res.result_kind = KIND_DONE;
            res.large_page = (st.phase == PHASE_DIR);
            res.granted_rights = entry_rights;
            if (perm_fault) begin
              st_next.rec_fault = st.pend_addr;
              res.physical_address = '1;
              res.status = STATUS_PERM_FAULT;
            end else begin
              res.physical_address = (st.phase == PHASE_DIR) ? pa_large : pa_small;
            end
          end
        end
        default: begin
          st_next.phase = PHASE_IDLE;
        end
      endcase
    end
    res.last_fault = st_next.rec_fault;
  end

endmodule

// ===== hw/rtl/tlpw_out_buf.sv =====
module tlpw_out_buf
  import tlpw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== hw/rtl/two_level_page_walker_unit.sv =====
// a result is registered in the output buffer when its request is accepted
// throughput: one request per cycle while in_ready is high; the walk state is updated at acceptance
// an output register plus one skid entry keep in_ready high while a single result waits
// reset (synchronous, rst high) clears the registers and the walk state and
// empties both output entries; no clearing pass is needed
module two_level_page_walker_unit
  import tlpw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [ADDR_W-1:0] fault_address,
  input  logic [2:0]        access_wanted,
  input  logic [ADDR_W-1:0] entry_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [ADDR_W-1:0] read_address,
  output logic [ADDR_W-1:0] physical_address,
  output logic              large_page,
  output logic [2:0]        granted_rights,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] last_fault
);

  cfg_t        cfg;
  walk_state_t st;
  walk_state_t st_next;
  logic        emit;
  logic        in_fire;
  result_t     step_res;
  result_t     out_data;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAGING_ON:     cfg.paging_on <= cfg_data[0];
        REG_WRITE_PROTECT: cfg.write_protect_on <= cfg_data[0];
        REG_DIR_BASE:      cfg.dir_base <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tlpw_step u_step (
    .mode          (mode),
    .fault_address (fault_address),
    .access_wanted (access_wanted),
    .entry_word    (entry_word),
    .cfg           (cfg),
    .st            (st),
    .st_next       (st_next),
    .emit          (emit),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PHASE_IDLE;
      st.pend_addr <= '0;
      st.pend_rights <= '0;
      st.rec_fault <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  tlpw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && emit),
    .push_data (step_res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign result_kind = out_data.result_kind;
  assign read_address = out_data.read_address;
  assign physical_address = out_data.physical_address;
  assign large_page = out_data.large_page;
  assign granted_rights = out_data.granted_rights;
  assign status = out_data.status;
  assign last_fault = out_data.last_fault;

`include "two_level_page_walker_unit_macros.svh"

  `TLPW_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid, "input stalled with empty output")
  `TLPW_ASSERT_NEXT(a_walk_starts, in_fire && mode == MODE_REQUEST && cfg.paging_on, st.phase == PHASE_DIR, "walk did not start")
  `TLPW_ASSERT_NOW(a_fault_all_ones, out_valid && result_kind == KIND_DONE && status != STATUS_OK, physical_address == '1, "fault without all-ones address")
  `TLPW_ASSERT_NOW(a_read_clean, out_valid && result_kind == KIND_READ, status == STATUS_OK && granted_rights == 3'd0 && physical_address == '0, "read request carries translation fields")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlpw_pkg::*;

  localparam logic MODE_RESPONSE = ~MODE_REQUEST;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1200;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [ADDR_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              mode;
  logic [ADDR_W-1:0] fault_address;
  logic [2:0]        access_wanted;
  logic [ADDR_W-1:0] entry_word;
  logic              out_valid;
  logic              out_ready;
  logic              result_kind;
  logic [ADDR_W-1:0] read_address;
  logic [ADDR_W-1:0] physical_address;
  logic              large_page;
  logic [2:0]        granted_rights;
  logic [1:0]        status;
  logic [ADDR_W-1:0] last_fault;

  two_level_page_walker_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .fault_address    (fault_address),
    .access_wanted    (access_wanted),
    .entry_word       (entry_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .read_address     (read_address),
    .physical_address (physical_address),
    .large_page       (large_page),
    .granted_rights   (granted_rights),
    .status           (status),
    .last_fault       (last_fault)
  );

  // translator copy of registers and walk state
  logic              tr_paging;
  logic              tr_wp;
  logic [ADDR_W-1:0] tr_dir_base;
  phase_t            tr_phase;
  logic [ADDR_W-1:0] tr_pend_addr;
  logic [2:0]        tr_pend_rights;
  logic [ADDR_W-1:0] tr_rec_fault;

  result_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned result_items = 0;
  int unsigned reg_writes = 0;
  int unsigned seen_reads = 0;
  int unsigned seen_done = 0;
  int unsigned seen_faults = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned idle_len(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_va();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] make_entry(bit present, bit writable, bit big_page);
    logic [ADDR_W-1:0] e;
    e = $urandom();
    e[ENTRY_VALID_BIT] = present;
    e[ENTRY_WRITE_BIT] = writable;
    e[ENTRY_LARGE_BIT] = big_page;
    return e;
  endfunction

  function automatic result_t finish_walk(logic [ADDR_W-1:0] pa, logic is_large,
                                          logic [2:0] rights);
    result_t r;
    r = '0;
    tr_phase = PHASE_IDLE;
    r.result_kind = KIND_DONE;
    r.large_page = is_large;
    r.granted_rights = rights;
    if (((rights & tr_pend_rights) != tr_pend_rights) && tr_wp) begin
      tr_rec_fault = tr_pend_addr;
      r.physical_address = '1;
      r.status = STATUS_PERM_FAULT;
    end else begin
      r.physical_address = pa;
      r.status = STATUS_OK;
    end
    return r;
  endfunction

  // returns 1 when the item gives a result
  function automatic bit translate_item(logic m, logic [ADDR_W-1:0] va, logic [2:0] want,
                                        logic [ADDR_W-1:0] entry);
    result_t r;
    logic [2:0] rights;
    r = '0;
    if (m == MODE_REQUEST) begin
      tr_pend_addr = va;
      tr_pend_rights = want;
      if (!tr_paging) begin
        tr_phase = PHASE_IDLE;
        r.result_kind = KIND_DONE;
        r.physical_address = va;
        r.granted_rights = RIGHTS_FULL;
        r.status = STATUS_OK;
      end else begin
        tr_phase = PHASE_DIR;
        r.result_kind = KIND_READ;
        r.read_address = {tr_dir_base[ADDR_W-1:SMALL_OFS_W], {SMALL_OFS_W{1'b0}}}
                         + {20'd0, va[31:22], 2'b00};
      end
    end else if (tr_phase != PHASE_DIR && tr_phase != PHASE_TAB) begin
      tr_phase = PHASE_IDLE;
      return 1'b0;
    end else if (!entry[ENTRY_VALID_BIT]) begin
      tr_phase = PHASE_IDLE;
      tr_rec_fault = tr_pend_addr;
      r.result_kind = KIND_DONE;
      r.physical_address = '1;
      r.granted_rights = RIGHTS_FULL;
      r.status = STATUS_NOT_PRESENT;
    end else begin
      rights = entry[ENTRY_WRITE_BIT] ? RIGHTS_FULL : RIGHTS_NO_WRITE;
      if (tr_phase == PHASE_TAB) begin
        r = finish_walk({entry[31:12], tr_pend_addr[11:0]}, 1'b0, rights);
      end else if (entry[ENTRY_LARGE_BIT]) begin
        r = finish_walk({entry[31:22], tr_pend_addr[21:0]}, 1'b1, rights);
      end else begin
        tr_phase = PHASE_TAB;
        r.result_kind = KIND_READ;
        r.read_address = {entry[31:12], 12'd0} + {20'd0, tr_pend_addr[21:12], 2'b00};
      end
    end
    r.last_fault = tr_rec_fault;
    pending_results.push_back(r);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", ADDR_W'(result_kind), ADDR_W'(want.result_kind));
        check_field("read_address", read_address, want.read_address);
        check_field("physical_address", physical_address, want.physical_address);
        check_field("large_page", ADDR_W'(large_page), ADDR_W'(want.large_page));
        check_field("granted_rights", ADDR_W'(granted_rights),
                    ADDR_W'(want.granted_rights));
        check_field("status", ADDR_W'(status), ADDR_W'(want.status));
        check_field("last_fault", last_fault, want.last_fault);
        if (want.result_kind == KIND_READ) begin
          seen_reads++;
        end else begin
          seen_done++;
          if (want.status != STATUS_OK) seen_faults++;
        end
      end
    end
  end

  initial begin : out_stall_drive
    int unsigned n;
    out_ready = 1'b0;
    forever begin
      n = idle_len(out_stalls_on);
      repeat (n) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      n = $urandom_range(1, 8);
      repeat (n) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic m, logic [ADDR_W-1:0] va, logic [2:0] want,
                           logic [ADDR_W-1:0] entry);
    int unsigned gap;
    gap = idle_len(in_gaps_on);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    fault_address <= va;
    access_wanted <= want;
    entry_word <= entry;
    do @(posedge clk); while (!in_ready);
    if (translate_item(m, va, want, entry)) result_items++;
  endtask

  task automatic send_request(logic [ADDR_W-1:0] va, logic [2:0] want);
    send_item(MODE_REQUEST, va, want, $urandom());
  endtask

  task automatic send_entry(logic [ADDR_W-1:0] entry);
    send_item(MODE_RESPONSE, $urandom(), 3'($urandom_range(0, 7)), entry);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ADDR_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PAGING_ON:     tr_paging = data[0];
      REG_WRITE_PROTECT: tr_wp = data[0];
      REG_DIR_BASE:      tr_dir_base = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_identity_map();
    write_reg(REG_PAGING_ON, 32'hFFFF_FFFE);
    send_request('0, 3'd0);
    send_request('1, 3'd7);
    send_request(32'h8000_0000, 3'd2);
    send_request($urandom(), 3'd5);
    // response with no walk open
    send_entry('1);
    send_request(32'h0000_0FFF, 3'd1);
    wait_idle();
  endtask

  task automatic test_directed_walks();
    write_reg(REG_DIR_BASE, '1);
    write_reg(REG_WRITE_PROTECT, 32'h0000_0001);
    write_reg(REG_PAGING_ON, 32'h0000_0001);
    send_request('1, 3'd7);
    send_entry(make_entry(1'b1, 1'b1, 1'b0));
    send_entry(make_entry(1'b1, 1'b1, 1'b0));
    // write wanted on a read-only small page
    send_request(32'h0040_1234, 3'd2);
    send_entry(make_entry(1'b1, 1'b1, 1'b0));
    send_entry(make_entry(1'b1, 1'b0, 1'b0));
    send_request('0, 3'd5);
    send_entry(32'h0000_0001);
    send_entry(32'h0000_0001);
    send_request(pick_va(), 3'd7);
    send_entry('1);
    send_request(pick_va(), 3'd6);
    send_entry(make_entry(1'b1, 1'b0, 1'b1));
    // missing directory entry, then missing table entry
    send_request(pick_va(), 3'd4);
    send_entry(32'hFFFF_FFFE);
    send_request(pick_va(), 3'd4);
    send_entry(make_entry(1'b1, 1'b1, 1'b0));
    send_entry('0);
    // new request drops the open walk
    send_request(pick_va(), 3'd3);
    send_request(pick_va(), 3'd1);
    send_entry(make_entry(1'b1, 1'b0, 1'b1));
    send_entry(make_entry(1'b1, 1'b1, 1'b0));
    wait_idle();
  endtask

  task automatic test_config_mid_walk();
    send_request(pick_va(), 3'd7);
    wait_idle();
    write_reg(REG_WRITE_PROTECT, 32'hFFFF_FFFE);
    write_reg(REG_DIR_BASE, '0);
    write_reg(REG_PAGING_ON, 32'h0000_0000);
    send_entry(make_entry(1'b1, 1'b0, 1'b0));
    send_entry(make_entry(1'b1, 1'b0, 1'b0));
    wait_idle();
    write_reg(REG_UNUSED, $urandom());
    write_reg(REG_PAGING_ON, 32'hFFFF_FFFF);
    write_reg(REG_WRITE_PROTECT, 32'hFFFF_FFFF);
    send_request(pick_va(), 3'd2);
    send_entry(make_entry(1'b1, 1'b0, 1'b1));
    wait_idle();
  endtask

  task automatic test_random_walks();
    int unsigned goal;
    int unsigned r;
    logic [ADDR_W-1:0] d;
    logic [ADDR_W-1:0] dir_entry;
    goal = result_items + RANDOM_ITEMS;
    while (result_items < goal) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: d = '0;
        1: d = '1;
        default: d = $urandom();
      endcase
      write_reg(REG_DIR_BASE, d);
      d = $urandom();
      d[0] = chance(50);
      write_reg(REG_WRITE_PROTECT, d);
      d = $urandom();
      d[0] = chance(85);
      write_reg(REG_PAGING_ON, d);
      if (chance(20)) write_reg(REG_UNUSED, $urandom());
      in_gaps_on = chance(75);
      out_stalls_on = chance(75);
      repeat (60) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_request(pick_va(), 3'($urandom_range(0, 7)));
          if (tr_paging) begin
            dir_entry = make_entry(chance(90), chance(50), chance(30));
            send_entry(dir_entry);
            if (dir_entry[ENTRY_VALID_BIT] && !dir_entry[ENTRY_LARGE_BIT])
              send_entry(make_entry(chance(90), chance(50), chance(50)));
          end
        end else if (r < 88) begin
          send_entry($urandom());
        end else if (r < 96) begin
          // walk left open, dropped by the next request
          send_request(pick_va(), 3'($urandom_range(0, 7)));
        end else begin
          wait_idle();
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_REQUEST;
    fault_address = '0;
    access_wanted = '0;
    entry_word = '0;
    tr_paging = 1'b0;
    tr_wp = 1'b0;
    tr_dir_base = '0;
    tr_phase = PHASE_IDLE;
    tr_pend_addr = '0;
    tr_pend_rights = '0;
    tr_rec_fault = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_identity_map();
    test_directed_walks();
    test_config_mid_walk();
    test_random_walks();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d entry reads and %0d finished translations, %0d of them faults",
             seen_reads, seen_done, seen_faults);
    $display("over %0d register writes, %0d mismatches", reg_writes, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tlpw_pkg.sv
hw/rtl/tlpw_step.sv
hw/rtl/tlpw_out_buf.sv
hw/rtl/two_level_page_walker_unit.sv
tb/tb_top.sv
